// File: src/mmpb_pkg.sv
// ----------------------------------------------------------------------------
// mmpb_pkg: shared types and constants for MIDI microtuning by pitch bend
// Field widths, codes and the control/status structs between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mmpb_pkg;

  localparam int NOTE_COUNT    = 128;
  localparam int CHANNEL_COUNT = 16;
  localparam int NOTE_W        = $clog2(NOTE_COUNT);
  localparam int CH_W          = $clog2(CHANNEL_COUNT);

  localparam int CENTS_W     = 24;
  localparam int RANGE_W     = 15;
  localparam int FRAC_SHIFT  = 13;
  localparam int NUM_W       = CENTS_W + FRAC_SHIFT;
  localparam int DEN_W       = 22;
  localparam int BEND_W      = 14;
  localparam int DIV_STEPS   = BEND_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [RANGE_W-1:0] RANGE_RESET = 15'd512;
  localparam logic [RANGE_W-1:0] RANGE_MIN   = 15'd256;
  localparam logic [RANGE_W-1:0] RANGE_MAX   = 15'd24576;
  localparam logic [DEN_W-1:0]   RANGE_SCALE = 22'd100;

  localparam logic [BEND_W-1:0] BEND_CENTER = 14'd8192;
  localparam logic [BEND_W-1:0] BEND_MAX    = 14'd16383;

  localparam logic [1:0] CMD_MSG   = 2'd0;
  localparam logic [1:0] CMD_TUNE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_BEND     = 4'hE;
  localparam logic [1:0] LEN_FULL    = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_TUNE,
    KIND_CLEAR,
    KIND_NOTE_ON,
    KIND_NOTE_OFF,
    KIND_PASS
  } item_kind_t;

  typedef enum logic [1:0] {
    RES_PASS,
    RES_BEND,
    RES_NOTE_ON,
    RES_NOTE_OFF
  } res_sel_t;

  typedef struct packed {
    logic     take;
    logic     tune_wr;
    logic     marks_clr;
    logic     mark_wr;
    logic     mark_set;
    logic     div_load;
    logic     div_chk;
    logic     div_step;
    logic     emit;
    res_sel_t sel;
    logic     last;
  } dp_cmd_t;

  typedef struct packed {
    item_kind_t kind;
    logic       active;
    logic       out_free;
  } dp_sts_t;

endpackage

// File: src/mmpb_ram.sv
// ----------------------------------------------------------------------------
// mmpb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mmpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/mmpb_dp.sv
// ----------------------------------------------------------------------------
// mmpb_dp: datapath
// Item register, tuning and active-note stores, restoring divider for the
// bend value and the output register.
// ----------------------------------------------------------------------------
module mmpb_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             in_command,
  input  logic [7:0]             in_status_byte,
  input  logic [6:0]             in_data_one,
  input  logic [6:0]             in_data_two,
  input  logic [1:0]             in_msg_length,
  input  logic [15:0]            in_sample_offset,
  input  logic [6:0]             in_table_index,
  input  logic signed [23:0]     in_table_cents,
  input  logic                   cfg_wr_en,
  input  logic [14:0]            cfg_wr_data,
  input  mmpb_pkg::dp_cmd_t      cmd,
  output mmpb_pkg::dp_sts_t      sts,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_status,
  output logic [6:0]             out_data_one,
  output logic [6:0]             out_data_two,
  output logic [1:0]             out_length,
  output logic [15:0]            out_offset,
  output logic                   out_last
);

  // item register
  logic [7:0]  st_r;
  logic [6:0]  d1_r;
  logic [6:0]  d2_r;
  logic [1:0]  len_r;
  logic [15:0] off_r;

  mmpb_pkg::item_kind_t kind;

  logic [mmpb_pkg::RANGE_W-1:0] range_r;
  logic [mmpb_pkg::RANGE_W-1:0] range_c;
  logic [mmpb_pkg::DEN_W-1:0]   den_r;

  logic [mmpb_pkg::NOTE_COUNT-1:0]    tune_vld_r;
  logic [mmpb_pkg::CHANNEL_COUNT-1:0] row_vld_r;
  logic [mmpb_pkg::CENTS_W-1:0]       tune_rd;
  logic [mmpb_pkg::NOTE_COUNT-1:0]    row_rd;
  logic [mmpb_pkg::NOTE_COUNT-1:0]    row_cur;
  logic [mmpb_pkg::NOTE_COUNT-1:0]    row_bit;
  logic [mmpb_pkg::NOTE_COUNT-1:0]    row_wdata;

  logic [mmpb_pkg::CENTS_W-1:0] cents;
  logic [mmpb_pkg::CENTS_W-1:0] cents_mag;
  logic [mmpb_pkg::NUM_W-1:0]   rem_r;
  logic [mmpb_pkg::NUM_W-1:0]   dsr_r;
  logic [mmpb_pkg::BEND_W-1:0]  q_r;
  logic                         neg_r;
  logic                         ovf_r;
  logic                         ge;
  logic [mmpb_pkg::BEND_W:0]    neg_mag;
  logic [mmpb_pkg::BEND_W-1:0]  bend;

  logic [mmpb_pkg::CH_W-1:0] ch;
  logic                      out_valid_r;
  logic                      out_free;
  logic [7:0]                o_st;
  logic [6:0]                o_d1;
  logic [6:0]                o_d2;
  logic [1:0]                o_len;
  logic [7:0]                out_status_r;
  logic [6:0]                out_data_one_r;
  logic [6:0]                out_data_two_r;
  logic [1:0]                out_length_r;
  logic [15:0]               out_offset_r;
  logic                      out_last_r;

  assign ch = st_r[mmpb_pkg::CH_W-1:0];

  // item decode
  always_comb begin
    kind = mmpb_pkg::KIND_NONE;
    case (in_command)
      mmpb_pkg::CMD_TUNE:  kind = mmpb_pkg::KIND_TUNE;
      mmpb_pkg::CMD_CLEAR: kind = mmpb_pkg::KIND_CLEAR;
      mmpb_pkg::CMD_MSG: begin
        if ((in_status_byte[7:4] inside {mmpb_pkg::ST_NOTE_OFF, mmpb_pkg::ST_NOTE_ON}) &&
            in_msg_length == mmpb_pkg::LEN_FULL) begin
          if (in_status_byte[7:4] == mmpb_pkg::ST_NOTE_ON && in_data_two != 7'd0) begin
            kind = mmpb_pkg::KIND_NOTE_ON;
          end else begin
            kind = mmpb_pkg::KIND_NOTE_OFF;
          end
        end else begin
          kind = mmpb_pkg::KIND_PASS;
        end
      end
      default: kind = mmpb_pkg::KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      st_r  <= in_status_byte;
      d1_r  <= in_data_one;
      d2_r  <= in_data_two;
      len_r <= in_msg_length;
      off_r <= in_sample_offset;
    end
  end

  // bend range and divisor
  always_comb begin
    range_c = range_r;
    if (range_r < mmpb_pkg::RANGE_MIN) begin
      range_c = mmpb_pkg::RANGE_MIN;
    end else if (range_r > mmpb_pkg::RANGE_MAX) begin
      range_c = mmpb_pkg::RANGE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= mmpb_pkg::RANGE_RESET;
    end else if (cfg_wr_en) begin
      range_r <= cfg_wr_data;
    end
    den_r <= mmpb_pkg::DEN_W'(range_c) * mmpb_pkg::RANGE_SCALE;
  end

  // tuning store, entries never written read as zero
  mmpb_ram #(
    .WIDTH (mmpb_pkg::CENTS_W),
    .DEPTH (mmpb_pkg::NOTE_COUNT)
  ) u_tune_ram (
    .clk   (clk),
    .we    (cmd.tune_wr),
    .waddr (in_table_index),
    .wdata (in_table_cents),
    .raddr (in_data_one),
    .rdata (tune_rd)
  );

  // active marks, one row of notes per channel
  mmpb_ram #(
    .WIDTH (mmpb_pkg::NOTE_COUNT),
    .DEPTH (mmpb_pkg::CHANNEL_COUNT)
  ) u_mark_ram (
    .clk   (clk),
    .we    (cmd.mark_wr),
    .waddr (ch),
    .wdata (row_wdata),
    .raddr (in_status_byte[mmpb_pkg::CH_W-1:0]),
    .rdata (row_rd)
  );

  always_comb begin
    row_cur   = row_vld_r[ch] ? row_rd : '0;
    row_bit   = mmpb_pkg::NOTE_COUNT'(1) << d1_r;
    row_wdata = cmd.mark_set ? (row_cur | row_bit) : (row_cur & ~row_bit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tune_vld_r <= '0;
      row_vld_r  <= '0;
    end else begin
      if (cmd.tune_wr) begin
        tune_vld_r[in_table_index] <= 1'b1;
      end
      if (cmd.marks_clr) begin
        row_vld_r <= '0;
      end else if (cmd.mark_wr) begin
        row_vld_r[ch] <= 1'b1;
      end
    end
  end

  // restoring divider on the magnitude: |cents| * 8192 / (range * 100)
  always_comb begin
    cents     = tune_vld_r[d1_r] ? tune_rd : '0;
    cents_mag = cents[mmpb_pkg::CENTS_W-1] ? (~cents + mmpb_pkg::CENTS_W'(1)) : cents;
    ge        = rem_r >= dsr_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg_r <= cents[mmpb_pkg::CENTS_W-1];
      rem_r <= {cents_mag, mmpb_pkg::FRAC_SHIFT'(0)};
      dsr_r <= mmpb_pkg::NUM_W'({den_r, mmpb_pkg::FRAC_SHIFT'(0)});
      q_r   <= '0;
    end else if (cmd.div_chk) begin
      ovf_r <= rem_r >= {dsr_r[mmpb_pkg::NUM_W-2:0], 1'b0};
    end else if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_r - dsr_r;
      end
      q_r   <= {q_r[mmpb_pkg::BEND_W-2:0], ge};
      dsr_r <= dsr_r >> 1;
    end
  end

  // floor toward minus infinity, then clamp to the wheel range
  always_comb begin
    neg_mag = {1'b0, q_r} + (mmpb_pkg::BEND_W + 1)'(rem_r != '0);
    if (!neg_r) begin
      if (ovf_r || q_r >= mmpb_pkg::BEND_CENTER) begin
        bend = mmpb_pkg::BEND_MAX;
      end else begin
        bend = mmpb_pkg::BEND_CENTER + q_r;
      end
    end else begin
      if (ovf_r || neg_mag > {1'b0, mmpb_pkg::BEND_CENTER}) begin
        bend = '0;
      end else begin
        bend = mmpb_pkg::BEND_CENTER - neg_mag[mmpb_pkg::BEND_W-1:0];
      end
    end
  end

  // result select
  always_comb begin
    o_st  = st_r;
    o_d1  = d1_r;
    o_d2  = d2_r;
    o_len = mmpb_pkg::LEN_FULL;
    case (cmd.sel)
      mmpb_pkg::RES_PASS: begin
        o_d1  = (len_r >= 2'd2) ? d1_r : 7'd0;
        o_d2  = (len_r >= 2'd3) ? d2_r : 7'd0;
        o_len = len_r;
      end
      mmpb_pkg::RES_BEND: begin
        o_st = {mmpb_pkg::ST_BEND, ch};
        o_d1 = bend[6:0];
        o_d2 = bend[13:7];
      end
      mmpb_pkg::RES_NOTE_ON:  o_st = {mmpb_pkg::ST_NOTE_ON, ch};
      mmpb_pkg::RES_NOTE_OFF: o_st = {mmpb_pkg::ST_NOTE_OFF, ch};
      default: o_st = st_r;
    endcase
  end

  // output register
  assign out_free = !out_valid_r || out_ready;

  assign sts = '{kind: kind, active: row_cur[d1_r], out_free: out_free};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit && out_free) begin
      out_status_r   <= o_st;
      out_data_one_r <= o_d1;
      out_data_two_r <= o_d2;
      out_length_r   <= o_len;
      out_offset_r   <= off_r;
      out_last_r     <= cmd.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_one = out_data_one_r;
  assign out_data_two = out_data_two_r;
  assign out_length   = out_length_r;
  assign out_offset   = out_offset_r;
  assign out_last     = out_last_r;

  a_mark_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_wr |-> $past(cmd.take))
    else $error("mark store written without a fresh item");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && !ovf_r) |-> (rem_r < {dsr_r[mmpb_pkg::NUM_W-2:0], 1'b0}))
    else $error("divider remainder out of range");

  a_first_is_bend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_status_r[7:4] == mmpb_pkg::ST_BEND))
    else $error("non-final result is not a pitch wheel message");

endmodule

// File: src/mmpb_ctrl.sv
// ----------------------------------------------------------------------------
// mmpb_ctrl: controller
// Sequences one item at a time: store reads, divider steps and emission
// of up to two results.
// ----------------------------------------------------------------------------
module mmpb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mmpb_pkg::dp_sts_t sts,
  output mmpb_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ON_RD,
    S_ON_CHK,
    S_ON_DIV,
    S_ON_BEND,
    S_ON_NOTE,
    S_OFF_RD,
    S_EMIT
  } state_t;

  state_t                         state_r;
  mmpb_pkg::res_sel_t             sel_r;
  logic [mmpb_pkg::DIV_CNT_W-1:0] cnt_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.sel       = mmpb_pkg::RES_PASS;
    cmd.take      = (state_r == S_IDLE) && in_valid;
    cmd.tune_wr   = cmd.take && sts.kind == mmpb_pkg::KIND_TUNE;
    cmd.marks_clr = cmd.take && sts.kind == mmpb_pkg::KIND_CLEAR;
    cmd.mark_wr   = (state_r == S_ON_RD) || (state_r == S_OFF_RD && sts.active);
    cmd.mark_set  = (state_r == S_ON_RD);
    cmd.div_load  = (state_r == S_ON_RD);
    cmd.div_chk   = (state_r == S_ON_CHK);
    cmd.div_step  = (state_r == S_ON_DIV);
    cmd.last      = 1'b1;
    case (state_r)
      S_EMIT: begin
        cmd.emit = 1'b1;
        cmd.sel  = sel_r;
      end
      S_ON_BEND: begin
        cmd.emit = 1'b1;
        cmd.sel  = mmpb_pkg::RES_BEND;
        cmd.last = 1'b0;
      end
      S_ON_NOTE: begin
        cmd.emit = 1'b1;
        cmd.sel  = mmpb_pkg::RES_NOTE_ON;
      end
      default: cmd.emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= mmpb_pkg::RES_PASS;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            case (sts.kind)
              mmpb_pkg::KIND_NOTE_ON:  state_r <= S_ON_RD;
              mmpb_pkg::KIND_NOTE_OFF: state_r <= S_OFF_RD;
              mmpb_pkg::KIND_PASS: begin
                sel_r   <= mmpb_pkg::RES_PASS;
                state_r <= S_EMIT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_ON_RD:  state_r <= S_ON_CHK;
        S_ON_CHK: begin
          cnt_r   <= '0;
          state_r <= S_ON_DIV;
        end
        S_ON_DIV: begin
          cnt_r <= cnt_r + mmpb_pkg::DIV_CNT_W'(1);
          if (cnt_r == mmpb_pkg::DIV_CNT_W'(mmpb_pkg::DIV_STEPS - 1)) begin
            state_r <= S_ON_BEND;
          end
        end
        S_ON_BEND: begin
          if (sts.out_free) begin
            state_r <= S_ON_NOTE;
          end
        end
        S_ON_NOTE: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_OFF_RD: begin
          sel_r   <= sts.active ? mmpb_pkg::RES_NOTE_OFF : mmpb_pkg::RES_PASS;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ON_DIV) |-> (cnt_r < mmpb_pkg::DIV_CNT_W'(mmpb_pkg::DIV_STEPS)))
    else $error("divider step count overran");

  a_bend_then_note: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ON_BEND && sts.out_free) |=> (state_r == S_ON_NOTE))
    else $error("pitch wheel message not followed by its note-on");

endmodule

// File: src/midi_microtuning_pitch_bend_top.sv
// ----------------------------------------------------------------------------
// midi_microtuning_pitch_bend_top: MIDI microtuning by pitch bend
// Retunes note-ons with a per-note cent table through the pitch wheel.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes a MIDI message or a command
// (write tuning entry, clear active notes). Result channel (out_valid/
// out_ready) gives one message per result; out_last marks the final result
// of an item. cfg_wr_en/cfg_wr_data write the bend range.
// Items are worked one at a time. A note-on passes a store read and a range
// check, then the restoring divider that forms the bend value (one quotient
// bit per cycle). The first result is registered from the emit step, which
// follows acceptance for pass-through, the store read for note-off and the
// divider for the pitch wheel of a note-on. A single output register
// separates the channels: the next item is taken while a result waits.
// When the receiver stalls, the block holds in its emit step until the
// output register frees up.
// Reset (synchronous, rst_n low) sets the range to 2 semitones, makes all
// tuning entries read as zero and clears every active note at once.
// ----------------------------------------------------------------------------
module midi_microtuning_pitch_bend_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_status_byte,
  input  logic [6:0]         in_data_one,
  input  logic [6:0]         in_data_two,
  input  logic [1:0]         in_msg_length,
  input  logic [15:0]        in_sample_offset,
  input  logic [6:0]         in_table_index,
  input  logic signed [23:0] in_table_cents,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_status,
  output logic [6:0]         out_data_one,
  output logic [6:0]         out_data_two,
  output logic [1:0]         out_length,
  output logic [15:0]        out_offset,
  output logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [14:0]        cfg_wr_data
);

  mmpb_pkg::dp_cmd_t cmd;
  mmpb_pkg::dp_sts_t sts;

  mmpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mmpb_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_status_byte   (in_status_byte),
    .in_data_one      (in_data_one),
    .in_data_two      (in_data_two),
    .in_msg_length    (in_msg_length),
    .in_sample_offset (in_sample_offset),
    .in_table_index   (in_table_index),
    .in_table_cents   (in_table_cents),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_data_one     (out_data_one),
    .out_data_two     (out_data_two),
    .out_length       (out_length),
    .out_offset       (out_offset),
    .out_last         (out_last)
  );

endmodule

// File: sim/tb_midi_microtuning_pitch_bend_top.sv
// ----------------------------------------------------------------------------
// tb_midi_microtuning_pitch_bend_top: self-checking bench for pitch bend retuning
// A queue-fed driver offers MIDI messages and commands. An internal retuning
// model predicts the emitted messages. A monitor compares each one as it
// arrives. Pacing on both channels and the bend range change between phases.
// ----------------------------------------------------------------------------
module tb_midi_microtuning_pitch_bend_top;

  localparam logic [1:0] CMD_NONE    = 2'd3;
  localparam int         RAND_ITEMS  = 340;
  localparam int         SETTLE      = 32;
  localparam int         HOLD_CYCLES = 400;
  localparam int         CYCLE_LIMIT = 1000000;

  typedef enum int {PACE_SLOW_RX, PACE_SLOW_TX, PACE_FULL} pace_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  status;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic [1:0]  len;
    logic [15:0] off;
    logic [6:0]  idx;
    logic [23:0] cents;
  } midi_in_t;

  typedef struct packed {
    logic [7:0]  status;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic [1:0]  len;
    logic [15:0] off;
    logic        last;
  } midi_out_t;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_ready;
  logic [1:0]         in_command       = '0;
  logic [7:0]         in_status_byte   = '0;
  logic [6:0]         in_data_one      = '0;
  logic [6:0]         in_data_two      = '0;
  logic [1:0]         in_msg_length    = '0;
  logic [15:0]        in_sample_offset = '0;
  logic [6:0]         in_table_index   = '0;
  logic signed [23:0] in_table_cents   = '0;
  logic               out_valid;
  logic               out_ready        = 1'b0;
  logic [7:0]         out_status;
  logic [6:0]         out_data_one;
  logic [6:0]         out_data_two;
  logic [1:0]         out_length;
  logic [15:0]        out_offset;
  logic               out_last;
  logic               cfg_wr_en        = 1'b0;
  logic [14:0]        cfg_wr_data      = '0;

  midi_microtuning_pitch_bend_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_status_byte   (in_status_byte),
    .in_data_one      (in_data_one),
    .in_data_two      (in_data_two),
    .in_msg_length    (in_msg_length),
    .in_sample_offset (in_sample_offset),
    .in_table_index   (in_table_index),
    .in_table_cents   (in_table_cents),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_data_one     (out_data_one),
    .out_data_two     (out_data_two),
    .out_length       (out_length),
    .out_offset       (out_offset),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // retuning model state
  logic [mmpb_pkg::RANGE_W-1:0]    model_range = mmpb_pkg::RANGE_RESET;
  logic [mmpb_pkg::CENTS_W-1:0]    model_cents [mmpb_pkg::NOTE_COUNT];
  logic [mmpb_pkg::NOTE_COUNT-1:0] model_marks [mmpb_pkg::CHANNEL_COUNT];

  midi_in_t  msg_backlog [$];
  midi_out_t midi_due [$];
  midi_in_t  msg_on_wire;
  midi_out_t msg_seen;
  midi_out_t msg_want;
  pace_t     pace = PACE_FULL;
  logic      hold_req = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_left = 0;
  int        fail_count = 0;
  int        cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [mmpb_pkg::BEND_W-1:0] bend_for(
      logic [mmpb_pkg::CENTS_W-1:0] cents);
    longint rng, num, den, q, b;
    rng = longint'(model_range);
    if (rng < longint'(mmpb_pkg::RANGE_MIN)) rng = longint'(mmpb_pkg::RANGE_MIN);
    if (rng > longint'(mmpb_pkg::RANGE_MAX)) rng = longint'(mmpb_pkg::RANGE_MAX);
    num = longint'($signed(cents)) * 8192;
    den = rng * longint'(mmpb_pkg::RANGE_SCALE);
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    b = q + longint'(mmpb_pkg::BEND_CENTER);
    if (b < 0) b = 0;
    else if (b > longint'(mmpb_pkg::BEND_MAX)) b = longint'(mmpb_pkg::BEND_MAX);
    return b[mmpb_pkg::BEND_W-1:0];
  endfunction

  function automatic void retune_item(midi_in_t m);
    logic [3:0]                  kind;
    logic [3:0]                  ch;
    logic [mmpb_pkg::BEND_W-1:0] bv;
    kind = m.status[7:4];
    ch = m.status[3:0];
    if (m.cmd == mmpb_pkg::CMD_TUNE) begin
      model_cents[m.idx] = m.cents;
      return;
    end
    if (m.cmd == mmpb_pkg::CMD_CLEAR) begin
      for (int c = 0; c < mmpb_pkg::CHANNEL_COUNT; c++) model_marks[c] = '0;
      return;
    end
    if (m.cmd != mmpb_pkg::CMD_MSG) return;
    if ((kind == mmpb_pkg::ST_NOTE_ON || kind == mmpb_pkg::ST_NOTE_OFF) &&
        m.len == mmpb_pkg::LEN_FULL) begin
      if (kind == mmpb_pkg::ST_NOTE_ON && m.d2 != 0) begin
        bv = bend_for(model_cents[m.d1]);
        model_marks[ch][m.d1] = 1'b1;
        midi_due.push_back('{{mmpb_pkg::ST_BEND, ch}, bv[6:0], bv[13:7],
                             mmpb_pkg::LEN_FULL, m.off, 1'b0});
        midi_due.push_back('{{mmpb_pkg::ST_NOTE_ON, ch}, m.d1, m.d2,
                             mmpb_pkg::LEN_FULL, m.off, 1'b1});
        return;
      end
      if (model_marks[ch][m.d1]) begin
        model_marks[ch][m.d1] = 1'b0;
        midi_due.push_back('{{mmpb_pkg::ST_NOTE_OFF, ch}, m.d1, m.d2,
                             mmpb_pkg::LEN_FULL, m.off, 1'b1});
        return;
      end
    end
    midi_due.push_back('{m.status, (m.len >= 2) ? m.d1 : 7'd0,
                         (m.len >= 3) ? m.d2 : 7'd0, m.len, m.off, 1'b1});
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic midi_in_t random_item();
    midi_in_t    m;
    logic [95:0] raw;
    int          pick;
    int          mag;
    logic [3:0]  ch;
    raw = {$urandom(), $urandom(), $urandom()};
    m = raw[$bits(midi_in_t)-1:0];
    pick = $urandom_range(0, 99);
    // small channel/note pools so note-offs find active notes
    ch = roll(60) ? 4'($urandom_range(0, 2)) : 4'($urandom());
    if (roll(60)) m.d1 = 7'($urandom_range(58, 65));
    if (pick < 12) begin
      m.cmd = mmpb_pkg::CMD_TUNE;
      if (roll(60)) m.idx = 7'($urandom_range(58, 65));
      if (roll(65)) begin
        mag = $urandom_range(0, 4000000);
        m.cents = roll(50) ? 24'(mag) : 24'(-mag);
      end
    end else if (pick < 47) begin
      m.cmd = mmpb_pkg::CMD_MSG;
      m.status = {mmpb_pkg::ST_NOTE_ON, ch};
      m.len = mmpb_pkg::LEN_FULL;
      if (m.d2 == 0) m.d2 = 7'd1;
    end else if (pick < 77) begin
      m.cmd = mmpb_pkg::CMD_MSG;
      m.len = mmpb_pkg::LEN_FULL;
      if (roll(50)) m.status = {mmpb_pkg::ST_NOTE_OFF, ch};
      else begin
        m.status = {mmpb_pkg::ST_NOTE_ON, ch};
        m.d2 = '0;
      end
    end else if (pick < 91) begin
      m.cmd = mmpb_pkg::CMD_MSG;
    end else if (pick < 93) begin
      m.cmd = mmpb_pkg::CMD_CLEAR;
    end else if (pick < 95) begin
      m.cmd = CMD_NONE;
    end
    return m;
  endfunction

  task automatic push_msg(logic [1:0] cmd, logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                          logic [1:0] len, logic [15:0] off, logic [6:0] idx,
                          logic [23:0] cents);
    msg_backlog.push_back('{cmd, st, d1, d2, len, off, idx, cents});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (msg_backlog.size() != 0 || in_valid || midi_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) retune_item(msg_on_wire);
      if (msg_backlog.size() != 0 &&
          !roll(pace == PACE_SLOW_RX ? 17 : pace == PACE_SLOW_TX ? 81 : 0)) begin
        msg_on_wire = msg_backlog.pop_front();
        in_valid         <= 1'b1;
        in_command       <= msg_on_wire.cmd;
        in_status_byte   <= msg_on_wire.status;
        in_data_one      <= msg_on_wire.d1;
        in_data_two      <= msg_on_wire.d2;
        in_msg_length    <= msg_on_wire.len;
        in_sample_offset <= msg_on_wire.off;
        in_table_index   <= msg_on_wire.idx;
        in_table_cents   <= msg_on_wire.cents;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver pacing, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !roll(pace == PACE_SLOW_RX ? 81 : pace == PACE_SLOW_TX ? 17 : 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      msg_seen = '{out_status, out_data_one, out_data_two, out_length, out_offset, out_last};
      if (midi_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected item: st=%h d1=%h d2=%h len=%0d off=%h last=%b",
                   msg_seen.status, msg_seen.d1, msg_seen.d2, msg_seen.len,
                   msg_seen.off, msg_seen.last);
      end else begin
        msg_want = midi_due.pop_front();
        if (msg_seen.status !== msg_want.status || msg_seen.d1 !== msg_want.d1 ||
            msg_seen.d2 !== msg_want.d2 || msg_seen.len !== msg_want.len ||
            msg_seen.off !== msg_want.off || msg_seen.last !== msg_want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp st=%h d1=%h d2=%h len=%0d off=%h last=%b",
                     msg_want.status, msg_want.d1, msg_want.d2, msg_want.len,
                     msg_want.off, msg_want.last,
                     " / got st=%h d1=%h d2=%h len=%0d off=%h last=%b",
                     msg_seen.status, msg_seen.d1, msg_seen.d2, msg_seen.len,
                     msg_seen.off, msg_seen.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("midi_microtuning_pitch_bend_top test failed");
      $finish;
    end
  end

  initial begin
    logic [14:0] range_set [6];
    midi_in_t    m;
    int          n;
    for (int i = 0; i < mmpb_pkg::NOTE_COUNT; i++) model_cents[i] = '0;
    for (int c = 0; c < mmpb_pkg::CHANNEL_COUNT; c++) model_marks[c] = '0;
    range_set[0] = '0;
    range_set[1] = 15'h7FFF;
    range_set[2] = mmpb_pkg::RANGE_MIN;
    range_set[3] = mmpb_pkg::RANGE_MAX;
    range_set[4] = 15'($urandom_range(257, 24575));
    range_set[5] = 15'($urandom());

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset range, clamped and exact bends, note-off forms
    push_msg(mmpb_pkg::CMD_TUNE,  8'h00,   0,   0, 2'd0, 16'h0000,   0, 24'h7FFFFF);
    push_msg(mmpb_pkg::CMD_TUNE,  8'h00,   0,   0, 2'd0, 16'h0000, 127, 24'h800000);
    push_msg(mmpb_pkg::CMD_TUNE,  8'h00,   0,   0, 2'd0, 16'h0000,  61, 24'hFFFFFF);
    push_msg(mmpb_pkg::CMD_TUNE,  8'h00,   0,   0, 2'd0, 16'h0000,  60, 24'h006400);
    push_msg(mmpb_pkg::CMD_MSG,   8'h90,   0, 127, 2'd3, 16'h0000,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'h9F, 127,   1, 2'd3, 16'hFFFF,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'h93,  61,  64, 2'd3, 16'h1234,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'h93,  60, 100, 2'd3, 16'h8000,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'h90,   0, 127, 2'd3, 16'h0001,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'h80,   0,  64, 2'd3, 16'h0002,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'h80,   0,  64, 2'd3, 16'h0003,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'h9F, 127,   0, 2'd3, 16'h0004,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'h93,  61,  55, 2'd2, 16'h0005,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'h83,  60,   5, 2'd1, 16'h0006,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'h90,   5,   5, 2'd0, 16'h0007,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'hF8, 127, 127, 2'd1, 16'h0008,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'hFF, 127, 127, 2'd3, 16'h0009,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'h00,  12,  34, 2'd3, 16'h000A,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'h7F,  56,  78, 2'd2, 16'h000B,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'hB3,   7, 100, 2'd3, 16'h000C,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_CLEAR, 8'h00,   0,   0, 2'd0, 16'h0000,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'h83,  60,   0, 2'd3, 16'h000D,   0, 24'h0);
    push_msg(CMD_NONE,            8'h90,  60, 100, 2'd3, 16'h000E,  60, 24'h7FFFFF);
    push_msg(mmpb_pkg::CMD_MSG,   8'hE5, 127, 127, 2'd3, 16'h000F,   0, 24'h0);
    push_msg(mmpb_pkg::CMD_MSG,   8'hA0,  64,  32, 2'd2, 16'h0010,   0, 24'h0);

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      pace = pace_t'(ph / 2);
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= range_set[ph];
      model_range = range_set[ph];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      @(negedge clk);
      if (ph == 4) hold_req = 1'b1;
      n = 0;
      while (n < RAND_ITEMS) begin
        m = random_item();
        msg_backlog.push_back(m);
        if (m.cmd != CMD_NONE) n++;
      end
    end

    wait_drained();
    if (fail_count == 0 && midi_due.size() == 0) begin
      $display("midi_microtuning_pitch_bend_top test passed");
    end else begin
      $display("midi_microtuning_pitch_bend_top test failed");
    end
    $finish;
  end

endmodule

// File: midi_microtuning_pitch_bend_top.f
src/mmpb_pkg.sv
src/mmpb_ram.sv
src/mmpb_dp.sv
src/mmpb_ctrl.sv
src/midi_microtuning_pitch_bend_top.sv
sim/tb_midi_microtuning_pitch_bend_top.sv
